@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen on a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ design/ksetr_pkg.sv @@
package ksetr_pkg;

  // Size of the key bitmaps and of the press queue
  localparam int NumKeys    = 256;
  localparam int QueueDepth = 16;

  localparam int KeyW    = 8;
  localparam int KeyIdxW = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int PtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW    = $clog2(QueueDepth + 1);
  localparam int QcntW   = 5;

  typedef enum logic [1:0] {
    OpKeyEvent  = 2'd0,
    OpFrameTick = 2'd1,
    OpQuery     = 2'd2,
    OpPop       = 2'd3
  } op_e;

  // Commands from the step logic to the press queue
  typedef struct packed {
    logic            push;
    logic            pop;
    logic            clear;
    logic [KeyW-1:0] key;
  } queue_req_t;

  // Queue outcome for the current step
  typedef struct packed {
    logic            pop_valid;
    logic [KeyW-1:0] pop_key;
    logic [CntW-1:0] count;
  } queue_sts_t;

endpackage

@@ design/key_state_edge_tracker_with_press_fifo.sv @@
// Key state edge tracker with a queue of newly pressed keys.
// Command channel: an item (opcode_i, key_code_i, key_level_i) is taken at a
// rising edge with start_i high and busy_o low. busy_o stays low, so an item
// may be issued in every cycle.
// Opcodes: key event, frame tick, query key, pop the pressed-key queue.
// Result channel: done_o is high for exactly one cycle per item, carrying the
// addressed key's down / just-pressed / just-released flags after the step,
// the pop outcome and the queue fill. Results come in item order.
// Path: the accepted item is held in the input register, then makes one
// pass through the bitmap and queue logic into the result register.
// Throughput: one item per cycle; state written by one item is seen by
// the next without a bubble.
// Reset: all keys up in both bitmaps, queue empty, no result pending.
// The receiver cannot stall: each result is presented once and then dropped.
`include "assert_macros.svh"

module key_state_edge_tracker_with_press_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  opcode_i,
  input  logic [ksetr_pkg::KeyW-1:0]  key_code_i,
  input  logic                        key_level_i,
  output logic                        done_o,
  output logic                        key_down_o,
  output logic                        just_pressed_o,
  output logic                        just_released_o,
  output logic [ksetr_pkg::KeyW-1:0]  popped_key_o,
  output logic                        popped_valid_o,
  output logic [ksetr_pkg::QcntW-1:0] queue_count_o
);
  import ksetr_pkg::*;

  logic               stage_valid_q;
  op_e                op_q;
  logic [KeyW-1:0]    key_q;
  logic               level_q;

  logic               in_range;
  logic [KeyIdxW-1:0] idx;
  logic               cur_rd;
  logic               prev_rd;
  logic               key_ev;
  logic               tick;
  logic               cur_after;
  logic               prev_after;
  queue_req_t         qreq;
  queue_sts_t         qsts;

  logic               done_q;
  logic               key_down_q, key_down_d;
  logic               pressed_q, pressed_d;
  logic               released_q, released_d;
  logic [KeyW-1:0]    popped_key_q, popped_key_d;
  logic               popped_valid_q;
  logic [QcntW-1:0]   qcount_q, qcount_d;

  assign busy_o = 1'b0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q    <= op_e'(opcode_i);
      key_q   <= key_code_i;
      level_q <= key_level_i;
    end
  end

  assign in_range = (32'(key_q) < NumKeys);
  assign idx      = KeyIdxW'(key_q);

  // Decode the held item into bitmap and queue commands
  always_comb begin
    key_ev     = 1'b0;
    tick       = 1'b0;
    qreq.push  = 1'b0;
    qreq.pop   = 1'b0;
    qreq.clear = 1'b0;
    qreq.key   = key_q;
    if (stage_valid_q) begin
      case (op_q)
        OpKeyEvent: begin
          key_ev    = in_range;
          qreq.push = in_range && level_q && !cur_rd;
        end
        OpFrameTick: begin
          tick       = 1'b1;
          qreq.clear = 1'b1;
        end
        OpQuery: begin
          key_ev = 1'b0;
        end
        OpPop: begin
          qreq.pop = 1'b1;
        end
        default: begin
          key_ev = 1'b0;
        end
      endcase
    end
  end

  ksetr_levels u_levels (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (idx),
    .wr_en_i (key_ev),
    .level_i (level_q),
    .tick_i  (tick),
    .cur_o   (cur_rd),
    .prev_o  (prev_rd)
  );

  ksetr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qreq),
    .sts_o  (qsts)
  );

  // Form the flags as they stand after this step
  assign cur_after    = key_ev ? level_q : cur_rd;
  assign prev_after   = tick ? cur_rd : prev_rd;
  assign key_down_d   = in_range && cur_after;
  assign pressed_d    = in_range && cur_after && !prev_after;
  assign released_d   = in_range && !cur_after && prev_after;
  assign popped_key_d = qsts.pop_valid ? qsts.pop_key : '0;
  assign qcount_d     = QcntW'(qsts.count);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_valid_q) begin
      key_down_q     <= key_down_d;
      pressed_q      <= pressed_d;
      released_q     <= released_d;
      popped_key_q   <= popped_key_d;
      popped_valid_q <= qsts.pop_valid;
      qcount_q       <= qcount_d;
    end
  end

  assign done_o          = done_q;
  assign key_down_o      = key_down_q;
  assign just_pressed_o  = pressed_q;
  assign just_released_o = released_q;
  assign popped_key_o    = popped_key_q;
  assign popped_valid_o  = popped_valid_q;
  assign queue_count_o   = qcount_q;

  `ASSERT_PROP(a_item_yields_result, clk_i, rst_ni, stage_valid_q |=> done_o, "result missing")
  `ASSERT_NEVER(a_edges_exclusive, clk_i, rst_ni, done_o && just_pressed_o && just_released_o, "both edges")
  `ASSERT_NEVER(a_pressed_is_down, clk_i, rst_ni, done_o && just_pressed_o && !key_down_o, "press without down")
  `ASSERT_NEVER(a_pop_only_on_pop, clk_i, rst_ni, qsts.pop_valid && !(stage_valid_q && op_q == OpPop), "stray pop")

endmodule

@@ design/ksetr_levels.sv @@
module ksetr_levels (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ksetr_pkg::KeyIdxW-1:0] idx_i,
  input  logic                         wr_en_i,
  input  logic                         level_i,
  input  logic                         tick_i,
  output logic                         cur_o,
  output logic                         prev_o
);
  import ksetr_pkg::*;

  logic [NumKeys-1:0] cur_q;
  logic [NumKeys-1:0] prev_q;

  // Record key levels and snapshot them on a frame tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      prev_q <= '0;
    end else begin
      if (wr_en_i) begin
        cur_q[idx_i] <= level_i;
      end
      if (tick_i) begin
        prev_q <= cur_q;
      end
    end
  end

  // Read the addressed key before this step's update
  assign cur_o  = cur_q[idx_i];
  assign prev_o = prev_q[idx_i];

endmodule

@@ design/ksetr_queue.sv @@
`include "assert_macros.svh"

module ksetr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ksetr_pkg::queue_req_t req_i,
  output ksetr_pkg::queue_sts_t sts_o
);
  import ksetr_pkg::*;

  localparam int SumW = CntW + 1;

  logic [KeyW-1:0] mem_q [QueueDepth];
  logic [KeyW-1:0] head_key_q;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic            full;
  logic            do_push;
  logic            do_pop;

  // Locate the free slot behind the last queued key
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(QueueDepth)) ?
                    PtrW'(tail_sum - SumW'(QueueDepth)) : PtrW'(tail_sum);

  assign full    = (count_q == CntW'(QueueDepth));
  assign do_push = req_i.push && !full;
  assign do_pop  = req_i.pop && (count_q != '0);

  // Advance head and fill count
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (req_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (do_push) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop) begin
      count_d = count_q - CntW'(1);
      head_d  = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Store a newly pressed key and hold the next head entry ready for a pop;
  // a push into the slot that becomes the head is forwarded straight through
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail] <= req_i.key;
    end
    if (do_push && (tail == head_d)) begin
      head_key_q <= req_i.key;
    end else begin
      head_key_q <= mem_q[head_d];
    end
  end

  assign sts_o.pop_valid = do_pop;
  assign sts_o.pop_key   = head_key_q;
  assign sts_o.count     = count_d;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(QueueDepth), "queue overfilled")
  `ASSERT_PROP(a_clear_empties, clk_i, rst_ni, req_i.clear |=> count_q == '0, "clear left keys")
  `ASSERT_PROP(a_pop_drops_one, clk_i, rst_ni, do_pop |=> count_q == $past(count_q) - CntW'(1), "pop count")

endmodule
